@@ rtl/block_fifo_with_drop_accounting_assert.svh @@
// assertion macros for the block fifo checker
`ifndef BLOCK_FIFO_WITH_DROP_ACCOUNTING_ASSERT_SVH
`define BLOCK_FIFO_WITH_DROP_ACCOUNTING_ASSERT_SVH

// same-cycle implication
`define BFDA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bfda assertion failed");

// next-cycle implication
`define BFDA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bfda assertion failed");

`endif

@@ rtl/bfda_pkg.sv @@
// shared types and codes for the block fifo with drop accounting
package bfda_pkg;

   typedef enum logic [2:0] {
      OP_WRITE   = 3'd0,
      OP_READ    = 3'd1,
      OP_DISCARD = 3'd2,
      OP_QUERY   = 3'd3,
      OP_CLEAR   = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_EMPTY   = 2'd2,
      ST_REFUSED = 2'd3
   } status_type;

   typedef struct packed {
      logic [2:0]  op;
      logic [15:0] count;
      logic [31:0] sample;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] read_sample;
      logic        block_end;
      logic [16:0] fill_level;
      logic [63:0] produced;
      logic [63:0] consumed;
      logic [63:0] dropped_total;
      logic [63:0] underrun_total;
   } rsp_type;

endpackage

@@ rtl/block_fifo_with_drop_accounting.sv @@
// block fifo with all-or-nothing blocks and drop and underrun accounting
//
// A ring of CAPACITY 32-bit samples (CAPACITY a power of two) held in one
// synchronous single-clock memory. An item is taken every cycle while the
// result path is not stalled. On acceptance the memory read and the
// pending stage are loaded; the output register is loaded from them
// when it is empty or being taken. The pending stage plus the output
// register let two results wait while the consumer holds rsp_ready low.
// Positions and counters update at the accepting edge, so back-to-back
// items always see the latest state. The sample memory is never cleared;
// only committed entries are ever read.
module block_fifo_with_drop_accounting #(
   parameter int CAPACITY = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  bfda_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bfda_pkg::rsp_type rsp_data
);
   import bfda_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int FW = AW + 1;

   logic [31:0]   store_ff [CAPACITY];
   logic [31:0]   rd_data_ff;

   logic [63:0]   wp_ff, wp_in, rp_ff, rp_in;
   logic [63:0]   drop_ff, drop_in, und_ff, und_in;
   logic [15:0]   wr_rem_ff, wr_rem_in, wr_len_ff, wr_len_in;
   logic [15:0]   rd_rem_ff, rd_rem_in, rd_len_ff, rd_len_in;
   logic          wr_adm_ff, wr_adm_in, rd_adm_ff, rd_adm_in;

   logic          pend_valid_ff;
   rsp_type       pend_ff, pend_in;
   logic          pend_rd_ff, pend_rd_in;
   logic          rsp_valid_ff;
   rsp_type       rsp_ff, rsp_in;

   logic          accept, pend_adv;
   logic          mem_we, mem_re;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [FW-1:0] fill;
   logic [15:0]   rem, len;
   logic          adm;

   assign pend_adv  = !rsp_valid_ff || rsp_ready;
   assign req_ready = !pend_valid_ff || pend_adv;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // committed fill never exceeds capacity, so the low bits carry it exactly
   assign fill = wp_ff[FW-1:0] - rp_ff[FW-1:0];

   always_comb begin
      wp_in      = wp_ff;
      rp_in      = rp_ff;
      drop_in    = drop_ff;
      und_in     = und_ff;
      wr_rem_in  = wr_rem_ff;
      wr_len_in  = wr_len_ff;
      wr_adm_in  = wr_adm_ff;
      rd_rem_in  = rd_rem_ff;
      rd_len_in  = rd_len_ff;
      rd_adm_in  = rd_adm_ff;
      pend_in    = '0;
      pend_rd_in = 1'b0;
      mem_we     = 1'b0;
      mem_re     = 1'b0;
      wr_addr    = '0;
      rd_addr    = '0;
      rem        = '0;
      len        = '0;
      adm        = 1'b0;
      unique case (req_data.op)
         OP_WRITE: begin
            rem = wr_rem_ff;
            len = wr_len_ff;
            adm = wr_adm_ff;
            if (rem == 16'd0) begin
               if (req_data.count == 16'd0) begin
                  pend_in.block_end = 1'b1;
               end else begin
                  rem = req_data.count;
                  len = req_data.count;
                  adm = ({1'b0, req_data.count} + 17'(fill)) <= 17'(CAPACITY);
                  if (!adm) begin
                     drop_in = drop_ff + 64'(req_data.count);
                  end
               end
            end
            if (rem != 16'd0) begin
               if (adm) begin
                  mem_we  = 1'b1;
                  wr_addr = wp_ff[AW-1:0] + AW'(len - rem);
               end else begin
                  pend_in.status = ST_FULL;
               end
               rem = rem - 16'd1;
               if (rem == 16'd0) begin
                  pend_in.block_end = 1'b1;
                  if (adm) begin
                     wp_in = wp_ff + 64'(len);
                  end
                  adm = 1'b0;
               end
            end
            wr_rem_in = rem;
            wr_len_in = len;
            wr_adm_in = adm;
         end
         OP_READ: begin
            rem = rd_rem_ff;
            len = rd_len_ff;
            adm = rd_adm_ff;
            if (rem == 16'd0) begin
               if (req_data.count == 16'd0) begin
                  pend_in.block_end = 1'b1;
               end else begin
                  rem = req_data.count;
                  len = req_data.count;
                  adm = 17'(req_data.count) <= 17'(fill);
                  if (!adm) begin
                     und_in = und_ff + 64'(17'(req_data.count) - 17'(fill));
                  end
               end
            end
            if (rem != 16'd0) begin
               if (adm) begin
                  mem_re     = 1'b1;
                  pend_rd_in = 1'b1;
                  rd_addr    = rp_ff[AW-1:0] + AW'(len - rem);
               end else begin
                  pend_in.status = ST_EMPTY;
               end
               rem = rem - 16'd1;
               if (rem == 16'd0) begin
                  pend_in.block_end = 1'b1;
                  if (adm) begin
                     rp_in = rp_ff + 64'(len);
                  end
                  adm = 1'b0;
               end
            end
            rd_rem_in = rem;
            rd_len_in = len;
            rd_adm_in = adm;
         end
         OP_DISCARD: begin
            if (req_data.count != 16'd0) begin
               if (rd_rem_ff != 16'd0 || 17'(req_data.count) > 17'(fill)) begin
                  pend_in.status = ST_REFUSED;
               end else begin
                  rp_in = rp_ff + 64'(req_data.count);
               end
            end
         end
         OP_QUERY: begin
            pend_in.fill_level     = (17'(fill) > 17'(CAPACITY)) ? 17'(CAPACITY)
                                                                 : 17'(fill);
            pend_in.produced       = wp_ff + drop_ff;
            pend_in.consumed       = rp_ff;
            pend_in.dropped_total  = drop_ff;
            pend_in.underrun_total = und_ff;
         end
         OP_CLEAR: begin
            wp_in     = '0;
            rp_in     = '0;
            drop_in   = '0;
            und_in    = '0;
            wr_rem_in = '0;
            wr_len_in = '0;
            wr_adm_in = 1'b0;
            rd_rem_in = '0;
            rd_len_in = '0;
            rd_adm_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_in = pend_ff;
      rsp_in.read_sample = pend_rd_ff ? rd_data_ff : 32'd0;
   end

   always_ff @(posedge clock) begin
      if (accept && mem_we) begin
         store_ff[wr_addr] <= req_data.sample;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && mem_re) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff     <= '0;
         rp_ff     <= '0;
         drop_ff   <= '0;
         und_ff    <= '0;
         wr_rem_ff <= '0;
         wr_len_ff <= '0;
         wr_adm_ff <= 1'b0;
         rd_rem_ff <= '0;
         rd_len_ff <= '0;
         rd_adm_ff <= 1'b0;
      end else if (accept) begin
         wp_ff     <= wp_in;
         rp_ff     <= rp_in;
         drop_ff   <= drop_in;
         und_ff    <= und_in;
         wr_rem_ff <= wr_rem_in;
         wr_len_ff <= wr_len_in;
         wr_adm_ff <= wr_adm_in;
         rd_rem_ff <= rd_rem_in;
         rd_len_ff <= rd_len_in;
         rd_adm_ff <= rd_adm_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (accept) begin
            pend_valid_ff <= 1'b1;
         end else if (pend_adv) begin
            pend_valid_ff <= 1'b0;
         end
         if (pend_adv) begin
            rsp_valid_ff <= pend_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pend_ff    <= pend_in;
         pend_rd_ff <= pend_rd_in;
      end
      if (pend_adv && pend_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

@@ rtl/bfda_checker.sv @@
// port-level checks for the block fifo, bound to the top level
`include "block_fifo_with_drop_accounting_assert.svh"

module bfda_checker #(
   parameter int CAPACITY = 1024
) (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input bfda_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input bfda_pkg::rsp_type rsp_data
);
   import bfda_pkg::*;

   `BFDA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
   `BFDA_ASSERT_NOW(a_fill_bound, clock, reset, rsp_valid, rsp_data.fill_level <= 17'(CAPACITY))
   `BFDA_ASSERT_NOW(a_err_no_totals, clock, reset, rsp_valid && rsp_data.status != ST_OK, rsp_data.fill_level == 17'd0 && rsp_data.consumed == 64'd0 && rsp_data.read_sample == 32'd0)
   `BFDA_ASSERT_NOW(a_sample_not_query, clock, reset, rsp_valid && rsp_data.read_sample != 32'd0, rsp_data.status == ST_OK && rsp_data.dropped_total == 64'd0 && rsp_data.produced == 64'd0)
   `BFDA_ASSERT_NOW(a_refused_no_end, clock, reset, rsp_valid && rsp_data.status == ST_REFUSED, !rsp_data.block_end)

endmodule

bind block_fifo_with_drop_accounting bfda_checker #(.CAPACITY(CAPACITY)) u_bfda_checker (.*);

@@ verif/tb_top.sv @@
// block fifo with drop accounting testbench: directed and random items, checked by a predictor
module tb_top;
   import bfda_pkg::*;

   localparam int CAPACITY = 1024;
   localparam int AW = $clog2(CAPACITY);
   localparam int CYCLE_LIMIT = 200000;

   class fifo_scoreboard;
      bit [31:0] ring [CAPACITY];
      bit [63:0] wr_pos, rd_pos, drop_cnt, under_cnt;
      int unsigned wr_left, wr_len, rd_left, rd_len;
      bit wr_ok, rd_ok;
      rsp_type pending [$];
      int unsigned errors, results, n_full, n_empty, n_refused, peak_fill;
      bit [63:0] top_wr_pos;

      function bit [63:0] stored_frames();
         return wr_pos - rd_pos;
      endfunction

      function bit idle();
         return pending.size() == 0;
      endfunction

      function void note_request(req_type item);
         rsp_type want;
         bit [63:0] level;
         logic [AW-1:0] addr;
         want = '0;
         level = stored_frames();
         case (item.op)
            OP_WRITE: begin
               if (wr_left == 0) begin
                  if (item.count == 0) begin
                     want.block_end = 1'b1;
                  end else begin
                     wr_len = 32'(item.count);
                     wr_left = 32'(item.count);
                     wr_ok = (item.count <= CAPACITY - level);
                     if (!wr_ok) drop_cnt += 64'(item.count);
                  end
               end
               if (wr_left != 0) begin
                  if (wr_ok) begin
                     addr = AW'(wr_pos + 64'(wr_len - wr_left));
                     ring[addr] = item.sample;
                  end else begin
                     want.status = ST_FULL;
                  end
                  wr_left--;
                  if (wr_left == 0) begin
                     want.block_end = 1'b1;
                     if (wr_ok) wr_pos += 64'(wr_len);
                     wr_ok = 1'b0;
                  end
               end
            end
            OP_READ: begin
               if (rd_left == 0) begin
                  if (item.count == 0) begin
                     want.block_end = 1'b1;
                  end else begin
                     rd_len = 32'(item.count);
                     rd_left = 32'(item.count);
                     rd_ok = (item.count <= level);
                     if (!rd_ok) under_cnt += 64'(item.count) - level;
                  end
               end
               if (rd_left != 0) begin
                  if (rd_ok) begin
                     addr = AW'(rd_pos + 64'(rd_len - rd_left));
                     want.read_sample = ring[addr];
                  end else begin
                     want.status = ST_EMPTY;
                  end
                  rd_left--;
                  if (rd_left == 0) begin
                     want.block_end = 1'b1;
                     if (rd_ok) rd_pos += 64'(rd_len);
                     rd_ok = 1'b0;
                  end
               end
            end
            OP_DISCARD: begin
               if (item.count != 0) begin
                  if (rd_left != 0 || item.count > level) want.status = ST_REFUSED;
                  else rd_pos += 64'(item.count);
               end
            end
            OP_QUERY: begin
               want.fill_level = 17'((level > CAPACITY) ? 64'(CAPACITY) : level);
               want.produced = wr_pos + drop_cnt;
               want.consumed = rd_pos;
               want.dropped_total = drop_cnt;
               want.underrun_total = under_cnt;
            end
            OP_CLEAR: begin
               wr_pos = 0;
               rd_pos = 0;
               drop_cnt = 0;
               under_cnt = 0;
               wr_left = 0;
               wr_len = 0;
               wr_ok = 1'b0;
               rd_left = 0;
               rd_len = 0;
               rd_ok = 1'b0;
            end
            default: ;
         endcase
         case (want.status)
            ST_FULL: n_full++;
            ST_EMPTY: n_empty++;
            ST_REFUSED: n_refused++;
            default: ;
         endcase
         if (stored_frames() > peak_fill) peak_fill = 32'(stored_frames());
         if (wr_pos > top_wr_pos) top_wr_pos = wr_pos;
         pending.push_back(want);
      endfunction

      function void compare_field(string name, logic [63:0] want, logic [63:0] got);
         if (got !== want) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            errors++;
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            $error("result arrived with no item outstanding");
            errors++;
            return;
         end
         want = pending.pop_front();
         results++;
         compare_field("status", 64'(want.status), 64'(got.status));
         compare_field("read_sample", 64'(want.read_sample), 64'(got.read_sample));
         compare_field("block_end", 64'(want.block_end), 64'(got.block_end));
         compare_field("fill_level", 64'(want.fill_level), 64'(got.fill_level));
         compare_field("produced", want.produced, got.produced);
         compare_field("consumed", want.consumed, got.consumed);
         compare_field("dropped_total", want.dropped_total, got.dropped_total);
         compare_field("underrun_total", want.underrun_total, got.underrun_total);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;

   fifo_scoreboard sb = new();
   int send_idle = 20;
   int recv_idle = 78;
   int hold_left = 0;
   int cycles = 0;
   int unsigned sent = 0;

   block_fifo_with_drop_accounting #(.CAPACITY(CAPACITY)) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_response(rsp_data);
   end

   function automatic req_type make_item(logic [2:0] op, logic [15:0] count,
                                         logic [31:0] sample);
      req_type item;
      item.op = op;
      item.count = count;
      item.sample = sample;
      return item;
   endfunction

   task automatic send_item(req_type item);
      @(negedge clock);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
      sb.note_request(item);
      sent++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (!sb.idle()) @(negedge clock);
   endtask

   function automatic req_type next_item(int phase);
      req_type item;
      int roll, sel, level, room, cap_len, w_cut, r_cut;
      item.op = OP_QUERY;
      item.count = 16'($urandom);
      item.sample = $urandom;
      level = int'(sb.stored_frames());
      room = CAPACITY - level;
      cap_len = (phase == 0) ? 16 : (phase == 1) ? 48 : 128;
      w_cut = (phase == 0) ? 40 : (phase == 1) ? 50 : 66;
      r_cut = w_cut + ((phase == 0) ? 38 : (phase == 1) ? 30 : 12);
      roll = $urandom_range(99);
      if (sb.wr_left != 0 && roll < 70) begin
         item.op = OP_WRITE;
         return item;
      end
      if (sb.rd_left != 0 && roll < 85) begin
         item.op = OP_READ;
         return item;
      end
      roll = $urandom_range(99);
      sel = $urandom_range(99);
      if (roll < w_cut) begin
         item.op = OP_WRITE;
         if (sb.wr_left == 0) begin
            if (sel < 5) item.count = 0;
            else if (sel < 20 && room + 4 <= 2 * cap_len)
               item.count = 16'(room + $urandom_range(1, 4));
            else if (sel < 30 && room > 0 && room <= 2 * cap_len) item.count = 16'(room);
            else item.count = 16'($urandom_range(1, cap_len));
         end
      end else if (roll < r_cut) begin
         item.op = OP_READ;
         if (sb.rd_left == 0) begin
            if (sel < 5) item.count = 0;
            else if (sel < 20 && level + 4 <= 2 * cap_len)
               item.count = 16'(level + $urandom_range(1, 4));
            else item.count = 16'($urandom_range(1, cap_len));
         end
      end else if (roll < r_cut + 7) begin
         item.op = OP_DISCARD;
         if (sel < 20) item.count = 0;
         else if (sel < 35) item.count = 16'(level + $urandom_range(1, 3));
         else item.count = 16'($urandom_range(0, level));
      end else if (roll < r_cut + 15) begin
         item.op = OP_QUERY;
      end else if (phase < 2 && roll < r_cut + 17) begin
         item.op = OP_CLEAR;
      end else begin
         item.op = 3'($urandom_range(5, 7));
      end
      return item;
   endfunction

   initial begin
      int quota [3];
      quota = '{300, 300, 475};
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      send_item(make_item(OP_QUERY, 16'h0000, 32'h0000_0000));
      send_item(make_item(OP_WRITE, 16'h0000, 32'h1234_5678));
      send_item(make_item(OP_READ, 16'h0000, 32'h0000_0000));
      send_item(make_item(OP_DISCARD, 16'h0000, 32'h0000_0000));
      send_item(make_item(OP_READ, 16'h0003, 32'h0000_0000));
      send_item(make_item(OP_READ, 16'hFFFF, 32'hFFFF_FFFF));
      send_item(make_item(OP_READ, 16'h0000, 32'h0000_0000));
      send_item(make_item(OP_WRITE, 16'h0004, 32'h0000_0000));
      send_item(make_item(OP_WRITE, 16'h0000, 32'hFFFF_FFFF));
      send_item(make_item(OP_WRITE, 16'hFFFF, 32'hA5A5_A5A5));
      send_item(make_item(OP_WRITE, 16'h0001, 32'h5A5A_5A5A));
      send_item(make_item(OP_DISCARD, 16'h0005, 32'h0000_0000));
      send_item(make_item(OP_READ, 16'h0002, 32'h0000_0000));
      // discard is refused while a read block is open
      send_item(make_item(OP_DISCARD, 16'h0001, 32'h0000_0000));
      send_item(make_item(OP_READ, 16'h0000, 32'h0000_0000));
      send_item(make_item(OP_DISCARD, 16'h0002, 32'h0000_0000));
      send_item(make_item(OP_WRITE, 16'd1025, 32'hDEAD_BEEF));
      send_item(make_item(OP_CLEAR, 16'hFFFF, 32'hFFFF_FFFF));
      send_item(make_item(OP_WRITE, 16'hFFFF, 32'hFFFF_FFFF));
      send_item(make_item(OP_READ, 16'hFFFF, 32'h0000_0000));
      send_item(make_item(OP_QUERY, 16'h0000, 32'h0000_0000));
      send_item(make_item(OP_CLEAR, 16'h0000, 32'h0000_0000));
      send_item(make_item(3'd5, 16'hFFFF, 32'hFFFF_FFFF));
      send_item(make_item(3'd6, 16'h0000, 32'h0000_0000));
      send_item(make_item(3'd7, 16'hFFFF, 32'hFFFF_FFFF));
      wait_drained();

      for (int phase = 0; phase < 3; phase++) begin
         int target;
         @(posedge clock);
         send_idle = (phase == 0) ? 20 : (phase == 1) ? 78 : 0;
         recv_idle = (phase == 0) ? 78 : (phase == 1) ? 20 : 0;
         // long receiver stall with the sender running flat out
         if (phase == 2) hold_left = 300;
         target = sent + quota[phase];
         while (sent < target) send_item(next_item(phase));
         wait_drained();
      end

      repeat (10) @(posedge clock);
      $display("covered %0d items and %0d results: %0d full, %0d empty, %0d refused",
               sent, sb.results, sb.n_full, sb.n_empty, sb.n_refused);
      $display("peak fill %0d of %0d, highest write position %0d",
               sb.peak_fill, CAPACITY, sb.top_wr_pos);
      if (sb.errors == 0 && sb.idle()) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule

@@ filelist.f @@
+incdir+rtl
rtl/bfda_pkg.sv
rtl/block_fifo_with_drop_accounting.sv
rtl/bfda_checker.sv
verif/tb_top.sv
